>>> sv/sqfx_pkg.sv
// Shared constants, types and arithmetic helpers for the fixed-point square root unit.
`default_nettype none

package sqfx_pkg;

  // Register stages from operand capture to the result register.
  localparam int NUM_STAGES = 9;

  // One load enable per register stage; bit 0 is the first stage.
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Linear interpolation across one octave.
  localparam logic [31:0] BASE_EVEN   = 32'd3037000499;
  localparam logic [31:0] BASE_ODD    = 32'd2147483648;
  localparam logic [31:0] SLOPE_EVEN  = 32'd1257966796;
  localparam logic [31:0] SLOPE_ODD   = 32'd889516851;

  // First parabolic correction.
  localparam logic [31:0] SPREAD_X    = 32'd1473799776;
  localparam logic [31:0] GAIN_Y_ODD  = 32'd1220935711;
  localparam logic [31:0] GAIN_Y_EVEN = 32'd1726663841;

  // Second parabolic correction.
  localparam logic [31:0] SPLIT_M     = 32'd1963258675;
  localparam logic [31:0] INV_LEFT    = 32'd2348995613;
  localparam logic [31:0] INV_RIGHT   = 32'd1977814028;
  localparam logic [31:0] GAIN_L_EVEN = 32'd417068;
  localparam logic [31:0] GAIN_L_ODD  = 32'd294912;
  localparam logic [31:0] GAIN_R_EVEN = 32'd379995;
  localparam logic [31:0] GAIN_R_ODD  = 32'd268697;

  localparam logic [31:0] HALF_WORD   = 32'h8000_0000;
  localparam logic [31:0] MAX_POS     = 32'h7FFF_FFFF;

  // Upper word of an unsigned 32x32 product.
  function automatic logic [31:0] hi_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] prod;
    prod = {32'd0, a} * {32'd0, b};
    return prod[63:32];
  endfunction

  // Bits below the leading one, left-aligned; a lone leading one leaves nothing.
  function automatic logic [31:0] mant_align(input logic [31:0] v, input logic [5:0] p);
    logic [5:0] sh;
    sh = 6'd33 - p;
    return sh[5] ? 32'd0 : (v << sh[4:0]);
  endfunction

  // Doubled distance of a mantissa from the middle of its range.
  function automatic logic [31:0] fold_d2(input logic [31:0] m);
    logic [31:0] d;
    d = m[31] ? (m - HALF_WORD) : (MAX_POS - m);
    return {d[30:0], 1'b0};
  endfunction

  // Octave shift of the result: (32 - p) / 2, for p in 1..32.
  function automatic logic [3:0] half_shift(input logic [5:0] p);
    logic [5:0] t;
    t = 6'd32 - p;
    return t[4:1];
  endfunction

  // Full octave shift: 32 - p, for p in 1..32.
  function automatic logic [4:0] tail_shift(input logic [5:0] p);
    logic [5:0] t;
    t = 6'd32 - p;
    return t[4:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/sqrt_fixed_16_16_approx_unit.sv
// Top level of the pipelined 32-bit integer to 16.16 fixed-point square root unit.
//
//   channel   | data     | handshake                     | transfer when
//   ----------+----------+-------------------------------+-----------------------------
//   operand   | operand  | operand_valid / operand_stall | valid high and stall low
//   root      | root     | root_valid / root_stall       | valid high and stall low
//
// Nine register stages from operand to root: two for normalization, six that each hold
// one 32x32 high-word product or its following add and shift, one for the final sum.
// One operand is taken every cycle while operand_stall is low, so operands overlap in the stages.
// A synchronous reset empties every stage; payload registers are not reset.
// Each stage holds while it is full and the one below it holds, so a stalled result
// backs up only as far as the first empty stage, and operand_stall rises only when
// all nine stages are full and root_stall is high.
`default_nettype none

module sqrt_fixed_16_16_approx_unit import sqfx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        operand_valid,
  output logic             operand_stall,
  input  wire logic [31:0] operand,
  output logic             root_valid,
  input  wire logic        root_stall,
  output logic [31:0]      root
);

  stage_en_t   en;
  stage_en_t   vld;
  logic [31:0] v2, m2;
  logic [5:0]  p2;
  logic [31:0] c1, c2;
  logic [31:0] lin_prod, lin4, lin5, lin6, lin7, lin8;
  logic [5:0]  p3;
  logic        zero3, zero4, zero5, zero6, zero7, zero8;
  logic [31:0] slope, base;

  // A stage loads when it is empty or the stage below it moves on.
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !root_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign operand_stall = !en[0];
  assign root_valid    = vld[NUM_STAGES-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= operand_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  sqfx_norm u_norm (
    .clk     (clk),
    .en      (en),
    .operand (operand),
    .v2      (v2),
    .p2      (p2),
    .m2      (m2)
  );

  sqfx_corr1 u_corr1 (
    .clk (clk),
    .en  (en),
    .v2  (v2),
    .p2  (p2),
    .m2  (m2),
    .c1  (c1)
  );

  sqfx_corr2 u_corr2 (
    .clk (clk),
    .en  (en),
    .p2  (p2),
    .m2  (m2),
    .c2  (c2)
  );

  // Linear interpolation across the octave, chosen by its parity.
  always_comb begin
    slope = p2[0] ? SLOPE_ODD : SLOPE_EVEN;
    base  = p3[0] ? BASE_ODD : BASE_EVEN;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lin_prod <= hi_mul(m2, slope);
      p3       <= p2;
      zero3    <= (p2 == 6'd0);
    end
    if (en[3]) begin
      lin4  <= (lin_prod + base) >> half_shift(p3);
      zero4 <= zero3;
    end
    if (en[4]) begin
      lin5  <= lin4;
      zero5 <= zero4;
    end
    if (en[5]) begin
      lin6  <= lin5;
      zero6 <= zero5;
    end
    if (en[6]) begin
      lin7  <= lin6;
      zero7 <= zero6;
    end
    if (en[7]) begin
      lin8  <= lin7;
      zero8 <= zero7;
    end
  end

  // Final wrapping sum; a zero operand gives zero.
  always_ff @(posedge clk) begin
    if (en[8]) begin
      root <= zero8 ? 32'd0 : (lin8 + c1 + c2);
    end
  end

endmodule

`default_nettype wire

>>> sv/sqfx_norm.sv
// Leading-one detection and mantissa alignment, two register stages.
`default_nettype none

module sqfx_norm import sqfx_pkg::*; (
  input  wire logic        clk,
  input  wire stage_en_t   en,
  input  wire logic [31:0] operand,
  output logic [31:0]      v2,
  output logic [5:0]       p2,
  output logic [31:0]      m2
);

  logic [31:0] v1;
  logic [5:0]  p1;
  logic [5:0]  pos;

  // Position of the highest set bit, counted from one; zero for a zero operand.
  always_comb begin
    pos = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (operand[i]) begin
        pos = 6'(i + 1);
      end
    end
  end

  // First stage holds the operand and its leading-one position.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      v1 <= operand;
      p1 <= pos;
    end
  end

  // Second stage adds the left-aligned mantissa.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      v2 <= v1;
      p2 <= p1;
      m2 <= mant_align(v1, p1);
    end
  end

endmodule

`default_nettype wire

>>> sv/sqfx_corr1.sv
// First parabolic correction: shifted operand, refolded mantissa, gain and octave scale.
`default_nettype none

module sqfx_corr1 import sqfx_pkg::*; (
  input  wire logic        clk,
  input  wire stage_en_t   en,
  input  wire logic [31:0] v2,
  input  wire logic [5:0]  p2,
  input  wire logic [31:0] m2,
  output logic [31:0]      c1
);

  logic [31:0] pa1, pa2, moved, d2a, pa3;
  logic [31:0] v3, v4;
  logic [5:0]  p3, p4, p5, p6, p7;
  logic [31:0] gain;
  logic [4:0]  c1_shift;

  // Square of the folded mantissa distance.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pa1 <= hi_mul(fold_d2(m2), fold_d2(m2));
      v3  <= v2;
      p3  <= p2;
    end
  end

  // Spread of the operand shift, taken from the parabola value.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      pa2 <= hi_mul(SPREAD_X, ~pa1);
      v4  <= v3;
      p4  <= p3;
    end
  end

  // Operand moved toward the error peak; the sum wraps.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      moved <= v4 + ((pa2 >> 4) >> tail_shift(p4));
      p5    <= p4;
    end
  end

  // Folded distance of the moved operand, aligned with the original position.
  always_ff @(posedge clk) begin
    if (en[5]) begin
      d2a <= fold_d2(mant_align(moved, p5));
      p6  <= p5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      pa3 <= hi_mul(d2a, d2a);
      p7  <= p6;
    end
  end

  // Gain by octave parity, then scale down to the octave.
  always_comb begin
    gain     = p7[0] ? GAIN_Y_ODD : GAIN_Y_EVEN;
    c1_shift = {1'b0, half_shift(p7)} + 5'd5;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      c1 <= hi_mul(~pa3, gain) >> c1_shift;
    end
  end

endmodule

`default_nettype wire

>>> sv/sqfx_corr2.sv
// Second parabolic correction, split left and right of the mantissa split point.
`default_nettype none

module sqfx_corr2 import sqfx_pkg::*; (
  input  wire logic        clk,
  input  wire stage_en_t   en,
  input  wire logic [5:0]  p2,
  input  wire logic [31:0] m2,
  output logic [31:0]      c2
);

  logic        left2, left3, left4, left5;
  logic [31:0] split_gap, scale;
  logic [31:0] pb1, pb2, pb3, pb4, pb5;
  logic [5:0]  p3, p4, p5;
  logic [31:0] qa, om, h, h2;
  logic [31:0] gain;

  // Distance from the split point and the slope of that side.
  always_comb begin
    left2     = m2 < SPLIT_M;
    split_gap = left2 ? (SPLIT_M - m2) : (m2 - SPLIT_M);
    scale     = left2 ? INV_LEFT : INV_RIGHT;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pb1   <= hi_mul(split_gap, scale);
      left3 <= left2;
      p3    <= p2;
    end
  end

  // Square of the scaled distance.
  assign qa = {pb1[29:0], 2'b00};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pb2   <= hi_mul(qa, qa);
      left4 <= left3;
      p4    <= p3;
    end
  end

  // Fold the inverted parabola around its middle and square again.
  always_comb begin
    om = ~pb2;
    h  = (om < HALF_WORD) ? (HALF_WORD - om) : (om - HALF_WORD);
    h2 = {h[30:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pb3   <= hi_mul(h2, h2);
      left5 <= left4;
      p5    <= p4;
    end
  end

  // Gain by side and octave parity, scaled to the octave.
  always_comb begin
    if (left5) begin
      gain = p5[0] ? GAIN_L_ODD : GAIN_L_EVEN;
    end else begin
      gain = p5[0] ? GAIN_R_ODD : GAIN_R_EVEN;
    end
    gain = gain >> half_shift(p5);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pb4 <= hi_mul(gain, ~pb3);
    end
  end

  // Delay to line up with the first correction.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      pb5 <= pb4;
    end
    if (en[7]) begin
      c2 <= pb5;
    end
  end

endmodule

`default_nettype wire

>>> sv/sqfx_check.sv
// Port-level checker for the square root unit, bound to the top level.
`default_nettype none

module sqfx_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        operand_valid,
  input wire logic        operand_stall,
  input wire logic [31:0] operand,
  input wire logic        root_valid,
  input wire logic        root_stall,
  input wire logic [31:0] root
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !root_valid)
    else $error("root_valid high after reset");

  // The input backs up only behind a full, stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    operand_stall |-> (root_valid && root_stall))
    else $error("operand_stall without a stalled result");

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (root_valid && root_stall) |=> root_valid)
    else $error("root_valid dropped under stall");

  // A stalled result keeps its value.
  a_hold_root: assert property (@(posedge clk) disable iff (rst)
    (root_valid && root_stall) |=> $stable(root))
    else $error("root changed under stall");

endmodule

bind sqrt_fixed_16_16_approx_unit sqfx_check u_sqfx_check (.*);

`default_nettype wire
